@@ rtl/bzc_pkg.sv @@
// ----------------------------------------------------------------------------
// bzc_pkg
// Shared types and constants of the Bezier curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bzc_pkg;

   // default number of fraction bits of the fixed-point format
   localparam int FRACTION_BITS_DEF = 12;

   // curve degree codes; the unused code evaluates as cubic
   localparam logic [1:0] OP_LINEAR = 2'd0;
   localparam logic [1:0] OP_QUAD   = 2'd1;
   localparam logic [1:0] OP_CUBIC  = 2'd2;

   // item data carried alongside the parameter divider
   typedef struct packed {
      logic [1:0]         operation;
      logic               t_zero;
      logic               t_full;
      logic signed [31:0] point_0;
      logic signed [31:0] point_1;
      logic signed [31:0] point_2;
      logic signed [31:0] point_3;
   } bzc_side_type;

endpackage

`default_nettype wire

@@ rtl/bzc_divider.sv @@
// ----------------------------------------------------------------------------
// bzc_divider
// Pipelined restoring divider, one quotient bit per stage, for the curve
// parameter. Each stage holds back only when it is full and its successor
// cannot take its data.
// ----------------------------------------------------------------------------
`default_nettype none

module bzc_divider
   import bzc_pkg::*;
#(
   parameter int FB = FRACTION_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [FB+20:0]       in_rem,
   input  wire logic [19:0]          in_div,
   input  wire bzc_side_type         in_side,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [FB:0]               out_quot,
   output bzc_side_type              out_side
);

   localparam int S  = FB + 1;
   localparam int NW = FB + 21;

   logic               v_ff    [S];
   logic [NW-1:0]      rem_ff  [S];
   logic [19:0]        div_ff  [S];
   logic [FB:0]        q_ff    [S];
   bzc_side_type       side_ff [S];
   logic [S:0]         rdy;

   assign rdy[S] = out_ready;

   for (genvar k = 0; k < S; k++) begin : g_stage
      localparam int SH = FB - k;
      logic          v_prev;
      logic [NW-1:0] rem_prev;
      logic [19:0]   div_prev;
      logic [FB:0]   q_prev;
      bzc_side_type  side_prev;
      logic [NW-1:0] dsh;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [FB:0]   q_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = in_rem;
         assign div_prev  = in_div;
         assign q_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign div_prev  = div_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      always_comb begin
         dsh    = NW'(div_prev) << SH;
         ge     = rem_prev >= dsh;
         rem_in = ge ? (rem_prev - dsh) : rem_prev;
         q_in   = q_prev;
         q_in[SH] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && v_prev) begin
            rem_ff[k]  <= rem_in;
            div_ff[k]  <= div_prev;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[S-1];
   assign out_quot  = q_ff[S-1];
   assign out_side  = side_ff[S-1];

endmodule

`default_nettype wire

@@ rtl/bezier_curve_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_core
// Fixed-point linear, quadratic and cubic Bezier curve evaluation.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. The block is a stall-tolerant
// pipeline that takes a new item every cycle unless stalled results fill it;
// its stages are one input stage, FRACTION_BITS + 1 divider stages that form
// the curve parameter t one bit at a time, four weight stages, one point
// multiply stage and the output register. Each stage moves on when its
// successor is free, so bubbles collapse and a stalled result only blocks
// the stages behind it once they are full.
`default_nettype none

module bezier_curve_evaluator_core
   import bzc_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_point_0,
   input  wire logic signed [31:0] req_point_1,
   input  wire logic signed [31:0] req_point_2,
   input  wire logic signed [31:0] req_point_3,
   input  wire logic signed [19:0] req_step_index,
   input  wire logic [18:0]        req_step_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_curve_value
);

   localparam int FB   = FRACTION_BITS;
   localparam int NW   = FB + 21;          // dividend width
   localparam int TW   = FB + 1;           // t, u and products of them
   localparam int PW   = 2 * TW;           // raw weight product
   localparam int WW   = FB + 3;           // final weight, up to 3.0
   localparam int PPW  = 32 + WW + 1;      // point times weight
   localparam logic [TW-1:0]  ONE   = TW'(1) << FB;
   localparam logic [PW-1:0]  HALF  = PW'(1) << (FB - 1);
   localparam logic [PPW-1:0] HALFP = PPW'(1) << (FB - 1);

   // ---------------- input stage: t special cases and dividend ----------------
   logic          s0_v_ff;
   logic [NW-1:0] s0_rem_ff;
   logic [19:0]   s0_div_ff;
   bzc_side_type  s0_side_ff;
   logic          s0_rdy;
   logic          div_in_ready;
   bzc_side_type  s0_side_in;
   logic [NW-1:0] s0_rem_in;

   always_comb begin
      s0_side_in.operation = req_operation;
      s0_side_in.t_zero    = req_step_index[19] || (req_step_index == 20'sd0);
      s0_side_in.t_full    = req_step_index >= $signed({1'b0, req_step_count});
      s0_side_in.point_0   = req_point_0;
      s0_side_in.point_1   = req_point_1;
      s0_side_in.point_2   = req_point_2;
      s0_side_in.point_3   = req_point_3;
      // (index << (FB+1)) + count, divided later by 2*count: rounded index/count
      s0_rem_in = (NW'(req_step_index[18:0]) << (FB + 1)) + NW'(req_step_count);
   end

   assign s0_rdy    = !s0_v_ff || div_in_ready;
   assign req_ready = s0_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_rdy && req_valid) begin
         s0_rem_ff  <= s0_rem_in;
         s0_div_ff  <= {req_step_count, 1'b0};
         s0_side_ff <= s0_side_in;
      end
   end

   // ---------------- divider ----------------
   logic         div_out_valid;
   logic [FB:0]  div_quot;
   bzc_side_type div_side;
   logic         w1_rdy;

   bzc_divider #(.FB(FB)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_v_ff),
      .in_ready  (div_in_ready),
      .in_rem    (s0_rem_ff),
      .in_div    (s0_div_ff),
      .in_side   (s0_side_ff),
      .out_valid (div_out_valid),
      .out_ready (w1_rdy),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // ---------------- W1: t and u = 1 - t ----------------
   logic          w1_v_ff;
   logic [TW-1:0] w1_t_ff, w1_u_ff;
   bzc_side_type  w1_side_ff;
   logic [TW-1:0] w1_t_in;
   logic          w2_rdy;

   always_comb begin
      if (div_side.t_zero) begin
         w1_t_in = '0;
      end else if (div_side.t_full) begin
         w1_t_in = ONE;
      end else begin
         w1_t_in = div_quot;
      end
   end

   assign w1_rdy = !w1_v_ff || w2_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_v_ff <= 1'b0;
      end else if (w1_rdy) begin
         w1_v_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (w1_rdy && div_out_valid) begin
         w1_t_ff    <= w1_t_in;
         w1_u_ff    <= ONE - w1_t_in;
         w1_side_ff <= div_side;
      end
   end

   // ---------------- W2: uu, tt, u*2t ----------------
   logic          w2_v_ff;
   logic [TW-1:0] w2_t_ff, w2_u_ff, w2_uu_ff, w2_tt_ff, w2_t2u_ff;
   bzc_side_type  w2_side_ff;
   logic [PW-1:0] uu_prod, tt_prod, tu_prod, uu_r, tt_r, t2u_r;
   logic          w3_rdy;

   always_comb begin
      uu_prod = PW'(w1_u_ff) * PW'(w1_u_ff);
      tt_prod = PW'(w1_t_ff) * PW'(w1_t_ff);
      tu_prod = PW'(w1_t_ff) * PW'(w1_u_ff);
      uu_r    = uu_prod + HALF;
      tt_r    = tt_prod + HALF;
      t2u_r   = {tu_prod[PW-2:0], 1'b0} + HALF;
   end

   assign w2_rdy = !w2_v_ff || w3_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         w2_v_ff <= 1'b0;
      end else if (w2_rdy) begin
         w2_v_ff <= w1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (w2_rdy && w1_v_ff) begin
         w2_t_ff    <= w1_t_ff;
         w2_u_ff    <= w1_u_ff;
         w2_uu_ff   <= uu_r[2*FB:FB];
         w2_tt_ff   <= tt_r[2*FB:FB];
         w2_t2u_ff  <= t2u_r[2*FB:FB];
         w2_side_ff <= w1_side_ff;
      end
   end

   // ---------------- W3: cubic terms ----------------
   logic          w3_v_ff;
   logic [TW-1:0] w3_t_ff, w3_u_ff, w3_uu_ff, w3_tt_ff, w3_t2u_ff;
   logic [TW-1:0] w3_uuu_ff, w3_tuu_ff, w3_utt_ff, w3_ttt_ff;
   bzc_side_type  w3_side_ff;
   logic [PW-1:0] uuu_r, tuu_r, utt_r, ttt_r;
   logic          w4_rdy;

   always_comb begin
      uuu_r = PW'(w2_uu_ff) * PW'(w2_u_ff) + HALF;
      tuu_r = PW'(w2_t_ff) * PW'(w2_uu_ff) + HALF;
      utt_r = PW'(w2_u_ff) * PW'(w2_tt_ff) + HALF;
      ttt_r = PW'(w2_tt_ff) * PW'(w2_t_ff) + HALF;
   end

   assign w3_rdy = !w3_v_ff || w4_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         w3_v_ff <= 1'b0;
      end else if (w3_rdy) begin
         w3_v_ff <= w2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (w3_rdy && w2_v_ff) begin
         w3_t_ff    <= w2_t_ff;
         w3_u_ff    <= w2_u_ff;
         w3_uu_ff   <= w2_uu_ff;
         w3_tt_ff   <= w2_tt_ff;
         w3_t2u_ff  <= w2_t2u_ff;
         w3_uuu_ff  <= uuu_r[2*FB:FB];
         w3_tuu_ff  <= tuu_r[2*FB:FB];
         w3_utt_ff  <= utt_r[2*FB:FB];
         w3_ttt_ff  <= ttt_r[2*FB:FB];
         w3_side_ff <= w2_side_ff;
      end
   end

   // ---------------- W4: weight select per degree ----------------
   logic          w4_v_ff;
   logic [WW-1:0] w4_w0_ff, w4_w1_ff, w4_w2_ff, w4_w3_ff;
   bzc_side_type  w4_side_ff;
   logic [WW-1:0] w0_in, w1_in, w2_in, w3_in;
   logic          p_rdy;

   always_comb begin
      case (w3_side_ff.operation)
         OP_LINEAR: begin
            w0_in = WW'(w3_u_ff);
            w1_in = WW'(w3_t_ff);
            w2_in = '0;
            w3_in = '0;
         end
         OP_QUAD: begin
            w0_in = WW'(w3_uu_ff);
            w1_in = WW'(w3_t2u_ff);
            w2_in = WW'(w3_tt_ff);
            w3_in = '0;
         end
         default: begin
            // cubic, also taken by the unused code
            w0_in = WW'(w3_uuu_ff);
            w1_in = WW'(w3_tuu_ff) + (WW'(w3_tuu_ff) << 1);
            w2_in = WW'(w3_utt_ff) + (WW'(w3_utt_ff) << 1);
            w3_in = WW'(w3_ttt_ff);
         end
      endcase
   end

   assign w4_rdy = !w4_v_ff || p_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         w4_v_ff <= 1'b0;
      end else if (w4_rdy) begin
         w4_v_ff <= w3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (w4_rdy && w3_v_ff) begin
         w4_w0_ff   <= w0_in;
         w4_w1_ff   <= w1_in;
         w4_w2_ff   <= w2_in;
         w4_w3_ff   <= w3_in;
         w4_side_ff <= w3_side_ff;
      end
   end

   // ---------------- P: point times weight, rounded half up ----------------
   logic                  p_v_ff;
   logic [31:0]           p_t0_ff, p_t1_ff, p_t2_ff, p_t3_ff;
   logic signed [PPW-1:0] pp0, pp1, pp2, pp3;
   logic                  out_rdy;

   always_comb begin
      pp0 = $signed(w4_side_ff.point_0) * $signed({1'b0, w4_w0_ff}) + $signed(HALFP);
      pp1 = $signed(w4_side_ff.point_1) * $signed({1'b0, w4_w1_ff}) + $signed(HALFP);
      pp2 = $signed(w4_side_ff.point_2) * $signed({1'b0, w4_w2_ff}) + $signed(HALFP);
      pp3 = $signed(w4_side_ff.point_3) * $signed({1'b0, w4_w3_ff}) + $signed(HALFP);
   end

   assign p_rdy = !p_v_ff || out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (p_rdy) begin
         p_v_ff <= w4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_rdy && w4_v_ff) begin
         p_t0_ff <= pp0[FB+31:FB];
         p_t1_ff <= pp1[FB+31:FB];
         p_t2_ff <= pp2[FB+31:FB];
         p_t3_ff <= pp3[FB+31:FB];
      end
   end

   // ---------------- output register: wrapping 32-bit sum ----------------
   logic        out_v_ff;
   logic [31:0] curve_ff;

   assign out_rdy = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && p_v_ff) begin
         curve_ff <= p_t0_ff + p_t1_ff + p_t2_ff + p_t3_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_curve_value = $signed(curve_ff);

`ifndef SYNTH
   // t never exceeds one
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      w1_v_ff |-> (w1_t_ff <= ONE))
      else $error("curve parameter above one");

   // t and u always add to one
   a_tu_sum: assert property (@(posedge clock) disable iff (reset)
      w1_v_ff |-> ((TW+1)'(w1_t_ff) + (TW+1)'(w1_u_ff)) == (TW+1)'(ONE))
      else $error("t and u do not sum to one");

   // input is held off only when the whole pipeline is backed up
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && p_v_ff && w4_v_ff))
      else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

@@ bench/bezier_checker.sv @@
// ----------------------------------------------------------------------------
// bezier_checker
// Watches both channels of the Bezier curve evaluator, predicts each curve
// value from the accepted request and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_checker
   import bzc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_point_0,
   input  wire logic signed [31:0] req_point_1,
   input  wire logic signed [31:0] req_point_2,
   input  wire logic signed [31:0] req_point_3,
   input  wire logic signed [19:0] req_step_index,
   input  wire logic [18:0]        req_step_count,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_curve_value,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRACTION_BITS_DEF;
   localparam longint ONE = longint'(1) << FB;

   logic signed [31:0] curve_queue[$];

   // rounding multiply: add half, floor shift, keep low 32 bits signed
   function automatic longint fx_mul(longint a, longint b);
      longint y;
      logic signed [31:0] cut;
      y = a * b + (longint'(1) << (FB - 1));
      cut = 32'(y >>> FB);
      return longint'(cut);
   endfunction

   function automatic longint step_to_t(logic signed [19:0] idx, logic [18:0] cnt);
      longint p;
      longint n;
      p = longint'(idx);
      n = longint'({1'b0, cnt});
      if (p <= 0) return 0;
      if (p >= n) return ONE;
      return ((p << (FB + 1)) + n) / (n << 1);
   endfunction

   function automatic logic signed [31:0] bezier_point_at(
      logic [1:0] op, logic signed [31:0] p0, logic signed [31:0] p1,
      logic signed [31:0] p2, logic signed [31:0] p3,
      logic signed [19:0] idx, logic [18:0] cnt);
      longint t;
      longint u;
      longint uu;
      longint tt;
      logic [31:0] sum;
      t = step_to_t(idx, cnt);
      u = ONE - t;
      sum = '0;
      if (op == OP_LINEAR) begin
         sum += 32'(fx_mul(p0, u));
         sum += 32'(fx_mul(p1, t));
      end else if (op == OP_QUAD) begin
         sum += 32'(fx_mul(p0, fx_mul(u, u)));
         sum += 32'(fx_mul(p1, fx_mul(u, fx_mul(t, 2 * ONE))));
         sum += 32'(fx_mul(p2, fx_mul(t, t)));
      end else begin
         // cubic, and the unused code falls here too
         uu = fx_mul(u, u);
         tt = fx_mul(t, t);
         sum += 32'(fx_mul(p0, fx_mul(uu, u)));
         sum += 32'(fx_mul(p1, fx_mul(fx_mul(t, uu), 3 * ONE)));
         sum += 32'(fx_mul(p2, fx_mul(fx_mul(u, tt), 3 * ONE)));
         sum += 32'(fx_mul(p3, fx_mul(tt, t)));
      end
      return signed'(sum);
   endfunction

   assign pending = curve_queue.size();

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         curve_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            curve_queue.push_back(bezier_point_at(req_operation, req_point_0,
               req_point_1, req_point_2, req_point_3, req_step_index,
               req_step_count));
         if (rsp_valid && rsp_ready) begin
            if (curve_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result transfer, value %h", $time,
                     rsp_curve_value);
               fail_count <= fail_count + 1;
            end else begin
               want = curve_queue.pop_front();
               if (want !== rsp_curve_value) begin
                  if (fail_count < 10)
                     $display("%0t: curve_value expected %h actual %h", $time,
                        want, rsp_curve_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Bezier curve evaluator: directed corners of t and the
// points, then bursty random requests against a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import bzc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = OP_LINEAR;
   logic signed [31:0] req_point_0 = '0;
   logic signed [31:0] req_point_1 = '0;
   logic signed [31:0] req_point_2 = '0;
   logic signed [31:0] req_point_3 = '0;
   logic signed [19:0] req_step_index = '0;
   logic [18:0]        req_step_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_curve_value;
   int                 fail_count;
   int                 pending;

   // unused operation code; the block treats it as cubic
   localparam logic [1:0] OP_SPARE = 2'd3;

   always #5 clock = ~clock;

   bezier_curve_evaluator_core DUT (.*);

   bezier_checker checker_i (.*);

   // receiver stall pattern: free-flowing, half or sparse, re-chosen at random
   int stall_mode = 0;
   int stall_tick = 0;
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0)
         stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // sender bursts: length left in the current burst before a gap
   int burst_left = 0;

   // present one request and hold it until the transfer happens
   task automatic send_curve(logic [1:0] op, logic signed [31:0] p0,
      logic signed [31:0] p1, logic signed [31:0] p2, logic signed [31:0] p3,
      logic signed [19:0] idx, logic [18:0] cnt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_operation  = op;
      req_point_0    = p0;
      req_point_1    = p1;
      req_point_2    = p2;
      req_point_3    = p3;
      req_step_index = idx;
      req_step_count = cnt;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand32();
      // mix full-range and small magnitudes so sums both wrap and stay sane
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0};
         default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   initial begin
      logic [1:0]  op;
      logic [18:0] cnt;
      logic [19:0] idx;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: t at zero, one, midpoints, extremes of every field
      send_curve(OP_LINEAR, 32'h0000_1000, 32'h0000_2000, '0, '0, 20'sd0, 19'd8);
      send_curve(OP_LINEAR, 32'h0000_1000, 32'h0000_2000, '0, '0, 20'sd8, 19'd8);
      send_curve(OP_LINEAR, 32'h7fff_ffff, 32'h8000_0000, '0, '0, 20'sd1, 19'd2);
      send_curve(OP_QUAD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0,
         20'sd3, 19'd7);
      send_curve(OP_CUBIC, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
         32'h7fff_ffff, 20'sd1, 19'd3);
      send_curve(OP_SPARE, 32'hffff_f000, 32'h0001_0000, 32'hfff0_0000,
         32'h0000_3000, 20'sd2, 19'd5);
      // negative index clamps to t = 0, most negative too
      send_curve(OP_CUBIC, 32'h1234_5678, 32'h1, 32'h2, 32'h3, -20'sd1, 19'd9);
      send_curve(OP_QUAD, 32'h0abc_0000, 32'h1, 32'h2, '0, 20'h80000, 19'd100);
      // zero step count: positive index gives t = 1, zero index t = 0
      send_curve(OP_CUBIC, 32'h1, 32'h2, 32'h3, 32'h0040_0000, 20'sd5, 19'd0);
      send_curve(OP_LINEAR, 32'h0040_0000, 32'h5, '0, '0, 20'sd0, 19'd0);
      // index past the count, largest index and count
      send_curve(OP_QUAD, 32'h1000, 32'h2000, 32'h3000, '0, 20'sd524287, 19'd7);
      send_curve(OP_CUBIC, 32'hdead_beef, 32'h0bad_f00d, 32'h1357_9bdf,
         32'hfedc_ba98, 20'sd524286, 19'd524287);
      send_curve(OP_LINEAR, 32'hffff_ffff, 32'h0, '0, '0, 20'sd1, 19'd524287);
      // halves that round up in the divider
      send_curve(OP_LINEAR, 32'h0010_0000, 32'h0, '0, '0, 20'sd1, 19'd8192);
      send_curve(OP_CUBIC, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 20'sd1, 19'd8191);
      // unused points carry garbage that must be ignored
      send_curve(OP_LINEAR, 32'h0000_1000, 32'h0000_1000, 32'hffff_ffff,
         32'h8000_0000, 20'sd1, 19'd4);
      send_curve(OP_QUAD, 32'h0000_1000, 32'h0000_1000, 32'h0000_1000,
         32'h7fff_ffff, 20'sd1, 19'd4);

      // random: mostly sensible sweeps, some full-width noise
      repeat (500) begin
         op = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 4) == 0) begin
            cnt = 19'($urandom());
            idx = 20'($urandom());
         end else begin
            cnt = ($urandom_range(0, 9) == 0) ? 19'($urandom()) :
               19'($urandom_range(0, 64));
            idx = 20'(signed'($urandom_range(0, int'(cnt) + 4)) - 2);
         end
         send_curve(op, rand32(), rand32(), rand32(), rand32(), idx, cnt);
      end
      req_valid = 1'b0;

      // drain, then watch a little longer for stray results
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
